@@ rtl/padded_integer_to_ascii_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the padded integer to ASCII formatter
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef PADDED_INTEGER_TO_ASCII_DEFINES_SVH
`define PADDED_INTEGER_TO_ASCII_DEFINES_SVH

// same-cycle implication
`define PIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pia_pkg.sv @@
// ----------------------------------------------------------------------------
// Padded integer to ASCII - package
// Widths, beat layout, character codes, job record and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package pia_pkg;

    localparam int VALUE_BITS      = 64;
    localparam int MAX_FIELD_WIDTH = 63;

    localparam int VALUE_W = 64;
    localparam int FW_W    = 6;
    localparam int CHAR_W  = 7;

    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int MAX_DIGITS_OD = (OCT_DIGITS > DEC_DIGITS) ? OCT_DIGITS : DEC_DIGITS;
    localparam int MAX_DIGITS = (MAX_DIGITS_OD > HEX_DIGITS) ? MAX_DIGITS_OD : HEX_DIGITS;
    localparam int OCT_W      = OCT_DIGITS * 3;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int BODY_W     = FW_W + 1;
    localparam int CONV_CNT_W = $clog2(VALUE_BITS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input beat layout
    localparam int TD_VALUE      = 0;
    localparam int TD_NEGATIVE   = TD_VALUE + VALUE_W;
    localparam int TD_FORCE_PLUS = TD_NEGATIVE + 1;
    localparam int TD_SPACE_SIGN = TD_FORCE_PLUS + 1;
    localparam int TD_ZERO_PAD   = TD_SPACE_SIGN + 1;
    localparam int TD_LEFT_ALIGN = TD_ZERO_PAD + 1;
    localparam int TD_FIELD_W    = TD_LEFT_ALIGN + 1;
    localparam int TD_EMPTY_ZERO = TD_FIELD_W + FW_W;
    localparam int IN_BITS       = TD_EMPTY_ZERO + 1;
    localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = ((CHAR_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;

    typedef enum logic [1:0] {
        MODE_OCT,
        MODE_DEC,
        MODE_HEX_LOWER,
        MODE_HEX_UPPER
    } radix_t;

    typedef enum logic [1:0] {
        PAD_LEAD,
        PAD_ZERO,
        PAD_TRAIL
    } pad_mode_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LEAD,
        B_SIGN,
        B_ZERO,
        B_DIGIT,
        B_TRAIL
    } back_state_t;

    typedef struct packed {
        logic [MAX_DIGITS-1:0][3:0] digits;
        logic [NDIG_W-1:0]          ndig;
        logic                       upper;
        logic                       has_sign;
        logic [CHAR_W-1:0]          sign_char;
        pad_mode_t                  pad_mode;
        logic [FW_W-1:0]            pad;
    } job_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        begin
            base = upper ? CH_UPPER_A : CH_LOWER_A;
            if (d < 4'd10)
            begin
                digit_char = CH_ZERO + {3'b000, d};
            end
            else
            begin
                digit_char = base + {3'b000, d} - 7'd10;
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/pia_front.sv @@
// ----------------------------------------------------------------------------
// Padded integer to ASCII - front end
// Accepts beats, splits the value into digits (shift-add-3 for decimal),
// works out sign and padding, pushes one job record per number bar empty zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pia_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [pia_pkg::IN_USER_W-1:0] s_tuser,
    input  wire logic                          q_full,
    output logic                               q_push,
    output pia_pkg::job_t                      q_job
);

    pia_pkg::front_state_t state_reg, state_next;

    logic [pia_pkg::MAX_DIGITS-1:0][3:0] dig_reg, dig_next;
    logic [pia_pkg::VALUE_BITS-1:0]      bin_reg;
    logic [pia_pkg::CONV_CNT_W-1:0]      cnt_reg;
    logic                                upper_reg;
    logic                                has_sign_reg;
    logic [pia_pkg::CHAR_W-1:0]          sign_char_reg;
    pia_pkg::pad_mode_t                  pad_mode_reg;
    logic [pia_pkg::FW_W-1:0]            width_reg;

    logic                           accept;
    logic                           drop;
    pia_pkg::radix_t                mode;
    logic [pia_pkg::VALUE_BITS-1:0] value;
    logic [pia_pkg::FW_W-1:0]       fw;
    logic [pia_pkg::OCT_W-1:0]      oct_bits;
    logic [pia_pkg::HEX_W-1:0]      hex_bits;

    logic [pia_pkg::DEC_DIGITS-1:0][3:0] adj;
    logic [pia_pkg::DEC_DIGITS-1:0]      carry;
    logic [pia_pkg::NDIG_W-1:0]          ndig;
    logic [pia_pkg::BODY_W-1:0]          body;

    assign accept   = s_tvalid && s_tready;
    assign mode     = pia_pkg::radix_t'(s_tuser);
    assign value    = s_tdata[pia_pkg::TD_VALUE +: pia_pkg::VALUE_BITS];
    assign fw       = s_tdata[pia_pkg::TD_FIELD_W +: pia_pkg::FW_W];
    assign drop     = s_tdata[pia_pkg::TD_EMPTY_ZERO] && (value == '0);
    assign oct_bits = pia_pkg::OCT_W'(value);
    assign hex_bits = pia_pkg::HEX_W'(value);

    // shift-add-3 step
    always_comb
    begin
        for (int i = 0; i < pia_pkg::DEC_DIGITS; i++)
        begin
            adj[i] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
        carry[0] = bin_reg[pia_pkg::VALUE_BITS-1];
        for (int i = 1; i < pia_pkg::DEC_DIGITS; i++)
        begin
            carry[i] = adj[i-1][3];
        end
    end

    always_comb
    begin
        dig_next = dig_reg;
        if (accept)
        begin
            dig_next = '0;
            unique case (mode)
                pia_pkg::MODE_OCT:
                begin
                    for (int i = 0; i < pia_pkg::OCT_DIGITS; i++)
                    begin
                        dig_next[i] = {1'b0, oct_bits[3*i +: 3]};
                    end
                end
                pia_pkg::MODE_HEX_LOWER, pia_pkg::MODE_HEX_UPPER:
                begin
                    for (int i = 0; i < pia_pkg::HEX_DIGITS; i++)
                    begin
                        dig_next[i] = hex_bits[4*i +: 4];
                    end
                end
                default:
                begin
                    dig_next = '0;
                end
            endcase
        end
        else if (state_reg == pia_pkg::F_CONV)
        begin
            for (int i = 0; i < pia_pkg::DEC_DIGITS; i++)
            begin
                dig_next[i] = {adj[i][2:0], carry[i]};
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pia_pkg::F_IDLE:
            begin
                if (accept && !drop)
                begin
                    state_next = (mode == pia_pkg::MODE_DEC) ? pia_pkg::F_CONV : pia_pkg::F_PUSH;
                end
            end
            pia_pkg::F_CONV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = pia_pkg::F_PUSH;
                end
            end
            pia_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = pia_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = pia_pkg::F_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = (state_reg == pia_pkg::F_IDLE);
        q_push   = (state_reg == pia_pkg::F_PUSH) && !q_full;

        ndig = pia_pkg::NDIG_W'(1);
        for (int i = 1; i < pia_pkg::MAX_DIGITS; i++)
        begin
            if (dig_reg[i] != 4'd0)
            begin
                ndig = pia_pkg::NDIG_W'(i + 1);
            end
        end
        body = pia_pkg::BODY_W'(ndig) + pia_pkg::BODY_W'(has_sign_reg);

        q_job.digits    = dig_reg;
        q_job.ndig      = ndig;
        q_job.upper     = upper_reg;
        q_job.has_sign  = has_sign_reg;
        q_job.sign_char = sign_char_reg;
        q_job.pad_mode  = pad_mode_reg;
        q_job.pad       = ({1'b0, width_reg} > body)
                        ? pia_pkg::FW_W'({1'b0, width_reg} - body) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pia_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        if (accept)
        begin
            bin_reg   <= value;
            cnt_reg   <= pia_pkg::CONV_CNT_W'(pia_pkg::VALUE_BITS - 1);
            upper_reg <= (mode == pia_pkg::MODE_HEX_UPPER);
            width_reg <= (fw > pia_pkg::FW_W'(pia_pkg::MAX_FIELD_WIDTH))
                       ? pia_pkg::FW_W'(pia_pkg::MAX_FIELD_WIDTH) : fw;
            has_sign_reg <= s_tdata[pia_pkg::TD_NEGATIVE] || s_tdata[pia_pkg::TD_FORCE_PLUS]
                         || s_tdata[pia_pkg::TD_SPACE_SIGN];
            priority if (s_tdata[pia_pkg::TD_NEGATIVE])
            begin
                sign_char_reg <= pia_pkg::CH_MINUS;
            end
            else if (s_tdata[pia_pkg::TD_FORCE_PLUS])
            begin
                sign_char_reg <= pia_pkg::CH_PLUS;
            end
            else
            begin
                sign_char_reg <= pia_pkg::CH_SPACE;
            end
            priority if (s_tdata[pia_pkg::TD_LEFT_ALIGN])
            begin
                pad_mode_reg <= pia_pkg::PAD_TRAIL;
            end
            else if (s_tdata[pia_pkg::TD_ZERO_PAD])
            begin
                pad_mode_reg <= pia_pkg::PAD_ZERO;
            end
            else
            begin
                pad_mode_reg <= pia_pkg::PAD_LEAD;
            end
        end
        else if (state_reg == pia_pkg::F_CONV)
        begin
            bin_reg <= {bin_reg[pia_pkg::VALUE_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pia_queue.sv @@
// ----------------------------------------------------------------------------
// Padded integer to ASCII - job queue
// Short FIFO of job records between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pia_pkg::job_t push_data,
    input  wire logic          pop,
    output pia_pkg::job_t      pop_data,
    output logic               full,
    output logic               empty
);

    pia_pkg::job_t mem [pia_pkg::QUEUE_DEPTH];

    logic [pia_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pia_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pia_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full     = (count_reg == pia_pkg::QCNT_W'(pia_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == pia_pkg::QPTR_W'(pia_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pia_pkg::QPTR_W'(pia_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pia_back.sv @@
// ----------------------------------------------------------------------------
// Padded integer to ASCII - back end
// Walks a job through lead pad, sign, zero pad, digits and trailing pad,
// one character per beat into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_empty,
    input  wire pia_pkg::job_t                  q_data,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pia_pkg::OUT_DATA_W-1:0]      m_tdata,   // [6:0] character
    output logic                                m_tlast
);

    pia_pkg::back_state_t state_reg, state_next;
    pia_pkg::job_t        job_reg, job_next;
    logic [pia_pkg::FW_W-1:0]   cnt_reg, cnt_next;
    logic                       tvalid_reg;
    logic [pia_pkg::CHAR_W-1:0] char_reg;
    logic                       tlast_reg;

    logic                          adv;
    logic                          emit;
    logic                          last;
    logic [pia_pkg::CHAR_W-1:0]    char_out;
    logic [pia_pkg::DIG_IDX_W-1:0] idx;

    function automatic pia_pkg::back_state_t next_after(input pia_pkg::back_state_t st,
                                                        input pia_pkg::job_t j);
        logic pad_on;
        begin
            pad_on = (j.pad != '0);
            unique case (st)
                pia_pkg::B_IDLE:
                begin
                    priority if (pad_on && j.pad_mode == pia_pkg::PAD_LEAD)
                        next_after = pia_pkg::B_LEAD;
                    else if (j.has_sign)
                        next_after = pia_pkg::B_SIGN;
                    else if (pad_on && j.pad_mode == pia_pkg::PAD_ZERO)
                        next_after = pia_pkg::B_ZERO;
                    else
                        next_after = pia_pkg::B_DIGIT;
                end
                pia_pkg::B_LEAD:
                    next_after = j.has_sign ? pia_pkg::B_SIGN : pia_pkg::B_DIGIT;
                pia_pkg::B_SIGN:
                    next_after = (pad_on && j.pad_mode == pia_pkg::PAD_ZERO)
                               ? pia_pkg::B_ZERO : pia_pkg::B_DIGIT;
                pia_pkg::B_ZERO:
                    next_after = pia_pkg::B_DIGIT;
                pia_pkg::B_DIGIT:
                    next_after = (pad_on && j.pad_mode == pia_pkg::PAD_TRAIL)
                               ? pia_pkg::B_TRAIL : pia_pkg::B_IDLE;
                default:
                    next_after = pia_pkg::B_IDLE;
            endcase
        end
    endfunction

    function automatic logic [pia_pkg::FW_W-1:0] phase_len(input pia_pkg::back_state_t st,
                                                           input pia_pkg::job_t j);
        begin
            unique case (st)
                pia_pkg::B_LEAD, pia_pkg::B_ZERO, pia_pkg::B_TRAIL:
                    phase_len = j.pad;
                pia_pkg::B_SIGN:
                    phase_len = pia_pkg::FW_W'(1);
                pia_pkg::B_DIGIT:
                    phase_len = pia_pkg::FW_W'(j.ndig);
                default:
                    phase_len = '0;
            endcase
        end
    endfunction

    assign adv = !tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        job_next   = job_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            pia_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_data;
                    state_next = next_after(pia_pkg::B_IDLE, q_data);
                    cnt_next   = phase_len(state_next, q_data);
                end
            end
            default:
            begin
                if (adv)
                begin
                    if (cnt_reg == pia_pkg::FW_W'(1))
                    begin
                        state_next = next_after(state_reg, job_reg);
                        cnt_next   = phase_len(state_next, job_reg);
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        emit = (state_reg != pia_pkg::B_IDLE);
        last = (cnt_reg == pia_pkg::FW_W'(1))
            && (next_after(state_reg, job_reg) == pia_pkg::B_IDLE);
        idx  = pia_pkg::DIG_IDX_W'(cnt_reg - 1'b1);
        unique case (state_reg)
            pia_pkg::B_SIGN:  char_out = job_reg.sign_char;
            pia_pkg::B_ZERO:  char_out = pia_pkg::CH_ZERO;
            pia_pkg::B_DIGIT: char_out = pia_pkg::digit_char(job_reg.digits[idx], job_reg.upper);
            default:          char_out = pia_pkg::CH_SPACE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pia_pkg::B_IDLE;
            cnt_reg    <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (adv)
            begin
                tvalid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (adv && emit)
        begin
            char_reg  <= char_out;
            tlast_reg <= last;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = pia_pkg::OUT_DATA_W'(char_reg);
    assign m_tlast  = tlast_reg;

endmodule

`default_nettype wire

@@ rtl/padded_integer_to_ascii.sv @@
// ----------------------------------------------------------------------------
// Padded integer to ASCII - top level
// Path: front end (decimal adds a shift-add-3 conversion), job queue, then
// the back end with its registered output stage.
// Throughput: one character per cycle out unless m_tready stalls, with an idle
// back end state between numbers; the front takes a new number once the last job is pushed.
// Reset: asynchronous, clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module padded_integer_to_ascii (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // value, negative, force_plus, space_sign, zero_pad, left_align,
    // field_width, empty_if_zero
    input  wire logic [pia_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [pia_pkg::IN_USER_W-1:0] s_tuser,  // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pia_pkg::OUT_DATA_W-1:0]     m_tdata,  // character
    output logic                               m_tlast   // last
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    pia_pkg::job_t q_job;
    pia_pkg::job_t q_head;

    pia_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    pia_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_job),
        .pop       (q_pop),
        .pop_data  (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pia_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/pia_checker.sv @@
// ----------------------------------------------------------------------------
// Padded integer to ASCII - port checker
// Watches the output stream of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "padded_integer_to_ascii_defines.svh"

module pia_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [pia_pkg::OUT_DATA_W-1:0]    m_tdata,
    input wire logic                              m_tlast
);

    `PIA_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")

    `PIA_ASSERT_IMP(a_ascii, clk, rst_n, m_tvalid, m_tdata[7] == 1'b0,
        "character outside 7-bit range")

    `PIA_ASSERT_IMP(a_last_not_sign, clk, rst_n, m_tvalid && m_tlast,
        (m_tdata[6:0] != pia_pkg::CH_PLUS) && (m_tdata[6:0] != pia_pkg::CH_MINUS),
        "number ends on a sign")

    `PIA_ASSERT_IMP(a_out_known, clk, rst_n, m_tvalid,
        !$isunknown(m_tdata) && !$isunknown(m_tlast), "output beat carries unknown bits")

endmodule

bind padded_integer_to_ascii pia_checker u_pia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ sim/padded_integer_to_ascii_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Padded integer to ASCII - testbench
// Sends numbers with random radix, flags and field widths. Every number is
// formatted in the bench, and each character beat that comes out is checked
// in order against those characters, last flag included. Both sides stall at
// random, with one long output hold-off and one pause until the output drains.
// ----------------------------------------------------------------------------

module padded_integer_to_ascii_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_AT       = 25;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 150;
    localparam int BATCH_NUMBERS = 40;

    typedef struct {
        pia_pkg::radix_t                 mode;
        logic [pia_pkg::VALUE_W-1:0]     value;
        logic                            negative;
        logic                            force_plus;
        logic                            space_sign;
        logic                            zero_pad;
        logic                            left_align;
        logic [pia_pkg::FW_W-1:0]        field_width;
        logic                            empty_if_zero;
    } number_t;

    typedef struct {
        logic [pia_pkg::CHAR_W-1:0] character;
        logic                       last;
    } char_beat_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pia_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [pia_pkg::IN_USER_W-1:0]  s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pia_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;

    number_t    pending_numbers[$];
    char_beat_t expected_chars[$];
    number_t    offered;
    int         numbers_offered = 0;
    int         numbers_taken = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    wire        calm = (numbers_taken >= 75) && (numbers_taken < 100);

    padded_integer_to_ascii uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic number_t make_number(input pia_pkg::radix_t mode,
                                            input logic [pia_pkg::VALUE_W-1:0] value,
                                            input int neg, input int plus,
                                            input int space, input int zero,
                                            input int left, input int width,
                                            input int empty);
        number_t n;
        n.mode          = mode;
        n.value         = value;
        n.negative      = neg[0];
        n.force_plus    = plus[0];
        n.space_sign    = space[0];
        n.zero_pad      = zero[0];
        n.left_align    = left[0];
        n.field_width   = width[pia_pkg::FW_W-1:0];
        n.empty_if_zero = empty[0];
        return n;
    endfunction

    function automatic number_t random_number();
        number_t n;
        n.mode = pia_pkg::radix_t'($urandom_range(3));
        case ($urandom_range(9))
            0:       n.value = '0;
            1, 2, 3: n.value = pia_pkg::VALUE_W'($urandom_range(999));
            4, 5:    n.value = {32'd0, $urandom};
            6:       n.value = {$urandom, $urandom} >> $urandom_range(63);
            default: n.value = {$urandom, $urandom};
        endcase
        n.negative      = 1'($urandom_range(1));
        n.force_plus    = 1'($urandom_range(1));
        n.space_sign    = 1'($urandom_range(1));
        n.zero_pad      = 1'($urandom_range(1));
        n.left_align    = 1'($urandom_range(1));
        n.field_width   = ($urandom_range(3) == 0) ? pia_pkg::FW_W'($urandom_range(63))
                                                   : pia_pkg::FW_W'($urandom_range(24));
        n.empty_if_zero = ($urandom_range(2) == 0);
        return n;
    endfunction

    // Formats one number and queues its characters.
    function automatic void format_number(input number_t n);
        int unsigned                 radix;
        logic [pia_pkg::VALUE_W-1:0] rest;
        logic [3:0]                  d;
        logic [pia_pkg::CHAR_W-1:0]  digit_chars[$];
        logic [pia_pkg::CHAR_W-1:0]  line_chars[$];
        logic [pia_pkg::CHAR_W-1:0]  sign_ch;
        bit                          has_sign;
        int                          body;
        int                          pad;
        char_beat_t                  cb;
        if (n.empty_if_zero && n.value == '0)
            return;
        radix = (n.mode == pia_pkg::MODE_OCT) ? 8 : (n.mode == pia_pkg::MODE_DEC) ? 10 : 16;
        rest  = n.value;
        do
        begin
            d = 4'(rest % radix);
            if (d < 4'd10)
                digit_chars.push_front(pia_pkg::CH_ZERO + {3'b000, d});
            else
                digit_chars.push_front(((n.mode == pia_pkg::MODE_HEX_UPPER)
                                        ? pia_pkg::CH_UPPER_A : pia_pkg::CH_LOWER_A)
                                       + {3'b000, d} - 7'd10);
            rest = rest / radix;
        end
        while (rest != '0);
        has_sign = 1'b1;
        if (n.negative)
            sign_ch = pia_pkg::CH_MINUS;
        else if (n.force_plus)
            sign_ch = pia_pkg::CH_PLUS;
        else if (n.space_sign)
            sign_ch = pia_pkg::CH_SPACE;
        else
            has_sign = 1'b0;
        body = digit_chars.size() + (has_sign ? 1 : 0);
        pad  = (int'(n.field_width) > body) ? int'(n.field_width) - body : 0;
        if (!n.left_align && !n.zero_pad)
            repeat (pad) line_chars.push_back(pia_pkg::CH_SPACE);
        if (has_sign)
            line_chars.push_back(sign_ch);
        if (!n.left_align && n.zero_pad)
            repeat (pad) line_chars.push_back(pia_pkg::CH_ZERO);
        foreach (digit_chars[i])
            line_chars.push_back(digit_chars[i]);
        if (n.left_align)
            repeat (pad) line_chars.push_back(pia_pkg::CH_SPACE);
        foreach (line_chars[i])
        begin
            cb.character = line_chars[i];
            cb.last      = (i == line_chars.size() - 1);
            expected_chars.push_back(cb);
        end
    endfunction

    // input side: offer numbers at the falling edge
    always @(negedge clk)
    begin : drive_numbers
        logic [pia_pkg::IN_DATA_W-1:0] beat;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || numbers_taken == numbers_offered)
        begin
            if (pending_numbers.size() != 0
                && (calm || hold_left != 0 || $urandom_range(99) >= 38))
            begin
                offered = pending_numbers.pop_front();
                numbers_offered = numbers_offered + 1;
                beat = '0;
                beat[pia_pkg::TD_VALUE +: pia_pkg::VALUE_W] = offered.value;
                beat[pia_pkg::TD_NEGATIVE]                  = offered.negative;
                beat[pia_pkg::TD_FORCE_PLUS]                = offered.force_plus;
                beat[pia_pkg::TD_SPACE_SIGN]                = offered.space_sign;
                beat[pia_pkg::TD_ZERO_PAD]                  = offered.zero_pad;
                beat[pia_pkg::TD_LEFT_ALIGN]                = offered.left_align;
                beat[pia_pkg::TD_FIELD_W +: pia_pkg::FW_W]  = offered.field_width;
                beat[pia_pkg::TD_EMPTY_ZERO]                = offered.empty_if_zero;
                s_tvalid <= 1'b1;
                s_tdata  <= beat;
                s_tuser  <= offered.mode;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            format_number(offered);
            numbers_taken = numbers_taken + 1;
        end
    end

    // output side: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && numbers_taken >= HOLD_AT)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge clk)
    begin : check_chars
        char_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("character beat %h with nothing expected", m_tdata);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_tdata[pia_pkg::CHAR_W-1:0] !== want.character)
                begin
                    $error("character: expected %h, actual %h", want.character,
                           m_tdata[pia_pkg::CHAR_W-1:0]);
                    error_count = error_count + 1;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %b, actual %b", want.last, m_tlast);
                    error_count = error_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        pending_numbers.push_back(make_number(pia_pkg::MODE_OCT, 64'd0,
                                              0, 0, 0, 0, 0, 0, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, 64'd0,
                                              1, 1, 1, 1, 0, 20, 1));
        pending_numbers.push_back(make_number(pia_pkg::MODE_HEX_LOWER, 64'd0,
                                              0, 0, 0, 0, 1, 63, 1));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, 64'd0,
                                              0, 1, 0, 1, 0, 5, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_OCT, 64'd7,
                                              0, 0, 0, 0, 0, 0, 1));
        pending_numbers.push_back(make_number(pia_pkg::MODE_OCT, '1,
                                              0, 0, 0, 0, 0, 0, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, '1,
                                              0, 0, 0, 0, 0, 0, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_HEX_LOWER, '1,
                                              0, 0, 0, 0, 0, 0, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_HEX_UPPER, '1,
                                              0, 0, 0, 0, 0, 0, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, '1,
                                              1, 1, 1, 1, 0, 63, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, 64'd12345,
                                              0, 1, 1, 0, 0, 0, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, 64'd12345,
                                              0, 0, 1, 0, 0, 0, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_HEX_LOWER, 64'hABC,
                                              1, 0, 0, 1, 1, 30, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_OCT, 64'd511,
                                              0, 1, 0, 0, 1, 63, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, 64'd987,
                                              1, 0, 0, 0, 0, 40, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, 64'd1234567890,
                                              1, 0, 0, 1, 0, 3, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_HEX_UPPER, 64'hDEADBEEFCAFEF00D,
                                              0, 0, 1, 1, 0, 63, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_HEX_LOWER, 64'hDEADBEEFCAFEF00D,
                                              0, 1, 0, 0, 0, 17, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_OCT, 64'd1,
                                              0, 0, 0, 1, 0, 1, 0));
        pending_numbers.push_back(make_number(pia_pkg::MODE_DEC, 64'h8000000000000000,
                                              1, 0, 0, 1, 0, 21, 1));
        repeat (BATCH_NUMBERS) pending_numbers.push_back(random_number());

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // let the output drain completely before the second batch
        while (pending_numbers.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        repeat (BATCH_NUMBERS) pending_numbers.push_back(random_number());

        while (pending_numbers.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
